// ===== hdl/tick_to_minute_ohlc_bars_assert.svh =====
// Assertion macros shared by the OHLC bar builder.
`ifndef TICK_TO_MINUTE_OHLC_BARS_ASSERT_SVH
`define TICK_TO_MINUTE_OHLC_BARS_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define OHLC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define OHLC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ohlc_pkg.sv =====
// Shared types, constants and helper functions of the OHLC bar builder.
package ohlc_pkg;

    localparam int MIN_W       = 11;
    localparam int PRICE_W     = 32;
    localparam int TVOL_W      = 32;
    localparam int VOL_W       = 48;
    localparam int CNT_W       = 3;
    localparam int IV_W        = 22;
    localparam int PTR_W       = 2;
    localparam int MAX_INTERVALS = 4;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 192;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 22;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;

    localparam logic [MIN_W-1:0] LAST_MINUTE = 11'd1439;
    localparam logic [VOL_W-1:0] VOL_MAX     = {VOL_W{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IV0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IV3   = 3'd4;

    localparam logic [CNT_W-1:0] COUNT_RESET = 3'd2;
    localparam logic [IV_W-1:0]  IV0_RESET   = 22'd1413690;
    localparam logic [IV_W-1:0]  IV1_RESET   = 22'd1843980;
    localparam logic [IV_W-1:0]  IV2_RESET   = 22'd0;
    localparam logic [IV_W-1:0]  IV3_RESET   = 22'd0;

    // Input action codes carried on s_tuser.
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_CLOSE   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_CLOSE,
        OP_RESTART
    } op_t;

    typedef enum logic [2:0] {
        ST_TRADED,
        ST_FILLED,
        ST_NO_PRICE,
        ST_REJECTED,
        ST_DONE
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [MIN_W-1:0]   minute;
        logic [PRICE_W-1:0] price;
        logic [TVOL_W-1:0]  volume;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        logic [MAX_INTERVALS-1:0][IV_W-1:0] iv;
    } cfg_t;

    function automatic logic [MIN_W-1:0] clamp_minute(input logic [MIN_W-1:0] m);
        return (m > LAST_MINUTE) ? LAST_MINUTE : m;
    endfunction

    localparam logic [MIN_W-1:0] SLOT_RESET = clamp_minute(IV0_RESET[MIN_W-1:0]);

endpackage

// ===== hdl/tick_to_minute_ohlc_bars.sv =====
// Top level of the one-minute OHLC bar builder: config registers, front, queue, back.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid/s_tready    s_tuser action, s_tdata tick fields
//   m_        out        m_tvalid/m_tready    m_tuser status, m_tdata bar, m_tlast
//   cfg_wr_   in         cfg_wr_en            cfg_wr_index, cfg_wr_data
//
// One transaction per cycle is taken while the two-entry queue has room.
// A result passes through the queue and the back end's result register: the queue is
// written at the accepting edge, and the back end registers the result when it pops
// the entry from the queue, after its compare, min/max and 48-bit add.
// A stall on m_tready holds the result register and the back end; the queue
// absorbs two transactions before s_tready drops. Reset is synchronous and
// needs no clearing pass.
`include "tick_to_minute_ohlc_bars_assert.svh"

module tick_to_minute_ohlc_bars import ohlc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            s_tuser,   // action
    input  logic [S_TDATA_W-1:0]  s_tdata,   // tick_minute, tick_price, tick_volume
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2:0]            m_tuser,   // status
    output logic [M_TDATA_W-1:0]  m_tdata,   // bar_minute, open, high, low, close, volume
    output logic                  m_tlast,   // day_complete
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    cfg_t   cfg_reg;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_not_empty;
    entry_t q_entry;
    entry_t q_head;
    logic   out_no_bar;
    logic   out_has_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.count <= COUNT_RESET;
            cfg_reg.iv[0] <= IV0_RESET;
            cfg_reg.iv[1] <= IV1_RESET;
            cfg_reg.iv[2] <= IV2_RESET;
            cfg_reg.iv[3] <= IV3_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_COUNT: cfg_reg.count <= cfg_wr_data[CNT_W-1:0];
                REG_IV0:   cfg_reg.iv[0] <= cfg_wr_data[IV_W-1:0];
                REG_IV1:   cfg_reg.iv[1] <= cfg_wr_data[IV_W-1:0];
                REG_IV2:   cfg_reg.iv[2] <= cfg_wr_data[IV_W-1:0];
                REG_IV3:   cfg_reg.iv[3] <= cfg_wr_data[IV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ohlc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    ohlc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    ohlc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_not_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign out_no_bar   = m_tvalid && (m_tuser == ST_DONE || m_tuser == ST_REJECTED);
    assign out_has_room = !m_tvalid || m_tready;

    `OHLC_ASSERT_IMP(a_no_overflow, q_push, !q_full, "push into a full queue")
    `OHLC_ASSERT_IMP(a_pop_has_room, q_pop, q_not_empty && out_has_room, "pop without room")
    `OHLC_ASSERT_IMP(a_last_on_bar, m_tvalid && m_tlast, m_tuser <= ST_NO_PRICE, "bad last")
    `OHLC_ASSERT_IMP(a_done_zero, out_no_bar, m_tdata[M_TDATA_W-1:MIN_W] == '0, "bad data")

endmodule

// ===== hdl/ohlc_front.sv =====
// Front end: accepts ticks, decodes the action and queues work for the back end.
module ohlc_front import ohlc_pkg::*; (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_tuser,   // action
    input  logic [S_TDATA_W-1:0] s_tdata,   // tick_minute, tick_price, tick_volume, zero pad
    input  logic                 q_full,
    output logic                 q_push,
    output entry_t               q_entry
);

    logic accept;
    logic keep;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        keep       = 1'b1;
        q_entry.op = OP_TICK;
        case (s_tuser)
            ACT_TICK: begin
                q_entry.op = OP_TICK;
            end
            ACT_CLOSE: begin
                q_entry.op = OP_CLOSE;
            end
            ACT_RESTART: begin
                q_entry.op = OP_RESTART;
            end
            default: begin
                // The unused action is dropped here and never reaches the queue.
                keep = 1'b0;
            end
        endcase
        q_entry.minute = s_tdata[MIN_W-1:0];
        q_entry.price  = s_tdata[MIN_W+PRICE_W-1:MIN_W];
        q_entry.volume = s_tdata[MIN_W+PRICE_W+TVOL_W-1:MIN_W+PRICE_W];
    end

    assign q_push = accept && keep;

endmodule

// ===== hdl/ohlc_fifo.sv =====
// Short queue between the decode front end and the bar back end.
module ohlc_fifo import ohlc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   not_empty,
    output entry_t head
);

    entry_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/ohlc_back.sv =====
// Back end: folds ticks into the open bar, walks the schedule and registers results.
module ohlc_back import ohlc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    input  entry_t               q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2:0]           m_tuser,   // status
    output logic [M_TDATA_W-1:0] m_tdata,   // bar_minute, open, high, low, close, volume, pad
    output logic                 m_tlast    // day_complete
);

    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [MIN_W-1:0]   slot_reg, slot_next;
    logic [PRICE_W-1:0] open_reg, open_next;
    logic [PRICE_W-1:0] high_reg, high_next;
    logic [PRICE_W-1:0] low_reg, low_next;
    logic [PRICE_W-1:0] close_reg, close_next;
    logic [VOL_W-1:0]   vol_reg, vol_next;
    logic               has_trade_reg, has_trade_next;
    logic [PRICE_W-1:0] prev_close_reg, prev_close_next;
    logic               price_seen_reg, price_seen_next;
    logic               done_reg, done_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [MIN_W-1:0]   out_minute_reg, out_minute_next;
    logic [PRICE_W-1:0] out_open_reg, out_open_next;
    logic [PRICE_W-1:0] out_high_reg, out_high_next;
    logic [PRICE_W-1:0] out_low_reg, out_low_next;
    logic [PRICE_W-1:0] out_close_reg, out_close_next;
    logic [VOL_W-1:0]   out_vol_reg, out_vol_next;
    logic               out_last_reg, out_last_next;

    logic               go;
    logic [CNT_W-1:0]   used_cnt;
    logic [MIN_W-1:0]   cur_end;
    logic [PTR_W-1:0]   ptr_inc;
    logic [MIN_W-1:0]   next_start;
    logic               at_end;
    logic               last_iv;
    logic [VOL_W:0]     vol_sum;

    // The back end only moves when the result register is free or being emptied.
    assign go    = q_valid && (!out_valid_reg || m_tready);
    assign q_pop = go;

    always_comb begin
        if (cfg.count == '0) begin
            used_cnt = CNT_W'(1);
        end else if (cfg.count > CNT_W'(MAX_INTERVALS)) begin
            used_cnt = CNT_W'(MAX_INTERVALS);
        end else begin
            used_cnt = cfg.count;
        end
    end

    assign cur_end    = clamp_minute(cfg.iv[ptr_reg][IV_W-1:MIN_W]);
    assign ptr_inc    = ptr_reg + 1'b1;
    assign next_start = clamp_minute(cfg.iv[ptr_inc][MIN_W-1:0]);
    assign at_end     = (slot_reg >= cur_end);
    assign last_iv    = ({1'b0, ptr_reg} + CNT_W'(1)) >= used_cnt;
    assign vol_sum    = {1'b0, vol_reg} + {{(VOL_W+1-TVOL_W){1'b0}}, q_head.volume};

    always_comb begin
        ptr_next        = ptr_reg;
        slot_next       = slot_reg;
        open_next       = open_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        close_next      = close_reg;
        vol_next        = vol_reg;
        has_trade_next  = has_trade_reg;
        prev_close_next = prev_close_reg;
        price_seen_next = price_seen_reg;
        done_next       = done_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_minute_next = out_minute_reg;
        out_open_next   = out_open_reg;
        out_high_next   = out_high_reg;
        out_low_next    = out_low_reg;
        out_close_next  = out_close_reg;
        out_vol_next    = out_vol_reg;
        out_last_next   = out_last_reg;

        if (go) begin
            case (q_head.op)
                OP_RESTART: begin
                    ptr_next        = '0;
                    slot_next       = clamp_minute(cfg.iv[0][MIN_W-1:0]);
                    has_trade_next  = 1'b0;
                    vol_next        = '0;
                    price_seen_next = 1'b0;
                    done_next       = 1'b0;
                end
                OP_TICK: begin
                    if (done_reg || q_head.minute != slot_reg) begin
                        out_valid_next  = 1'b1;
                        out_status_next = done_reg ? ST_DONE : ST_REJECTED;
                        out_minute_next = slot_reg;
                        out_open_next   = '0;
                        out_high_next   = '0;
                        out_low_next    = '0;
                        out_close_next  = '0;
                        out_vol_next    = '0;
                        out_last_next   = 1'b0;
                    end else begin
                        if (!has_trade_reg) begin
                            open_next = q_head.price;
                            high_next = q_head.price;
                            low_next  = q_head.price;
                            vol_next  = {{(VOL_W-TVOL_W){1'b0}}, q_head.volume};
                        end else begin
                            if (q_head.price > high_reg) begin
                                high_next = q_head.price;
                            end
                            if (q_head.price < low_reg) begin
                                low_next = q_head.price;
                            end
                            vol_next = vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];
                        end
                        close_next      = q_head.price;
                        has_trade_next  = 1'b1;
                        price_seen_next = 1'b1;
                    end
                end
                OP_CLOSE: begin
                    out_valid_next  = 1'b1;
                    out_minute_next = slot_reg;
                    if (done_reg) begin
                        out_status_next = ST_DONE;
                        out_open_next   = '0;
                        out_high_next   = '0;
                        out_low_next    = '0;
                        out_close_next  = '0;
                        out_vol_next    = '0;
                        out_last_next   = 1'b0;
                    end else begin
                        out_last_next = at_end && last_iv;
                        if (has_trade_reg) begin
                            out_status_next = ST_TRADED;
                            out_open_next   = open_reg;
                            out_high_next   = high_reg;
                            out_low_next    = low_reg;
                            out_close_next  = close_reg;
                            out_vol_next    = vol_reg;
                            prev_close_next = close_reg;
                        end else if (price_seen_reg) begin
                            out_status_next = ST_FILLED;
                            out_open_next   = prev_close_reg;
                            out_high_next   = prev_close_reg;
                            out_low_next    = prev_close_reg;
                            out_close_next  = prev_close_reg;
                            out_vol_next    = '0;
                        end else begin
                            out_status_next = ST_NO_PRICE;
                            out_open_next   = '0;
                            out_high_next   = '0;
                            out_low_next    = '0;
                            out_close_next  = '0;
                            out_vol_next    = '0;
                        end
                        if (at_end) begin
                            if (last_iv) begin
                                done_next = 1'b1;
                            end else begin
                                ptr_next  = ptr_inc;
                                slot_next = next_start;
                            end
                        end else begin
                            slot_next = slot_reg + 1'b1;
                        end
                        has_trade_next = 1'b0;
                        vol_next       = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg        <= '0;
            slot_reg       <= SLOT_RESET;
            has_trade_reg  <= 1'b0;
            price_seen_reg <= 1'b0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            ptr_reg        <= ptr_next;
            slot_reg       <= slot_next;
            has_trade_reg  <= has_trade_next;
            price_seen_reg <= price_seen_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        open_reg       <= open_next;
        high_reg       <= high_next;
        low_reg        <= low_next;
        close_reg      <= close_next;
        vol_reg        <= vol_next;
        prev_close_reg <= prev_close_next;
        out_status_reg <= out_status_next;
        out_minute_reg <= out_minute_next;
        out_open_reg   <= out_open_next;
        out_high_reg   <= out_high_next;
        out_low_reg    <= out_low_next;
        out_close_reg  <= out_close_next;
        out_vol_reg    <= out_vol_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W-MIN_W-4*PRICE_W-VOL_W){1'b0}}, out_vol_reg,
                       out_close_reg, out_low_reg, out_high_reg, out_open_reg,
                       out_minute_reg};

endmodule

// ===== dv/tick_to_minute_ohlc_bars_tb.sv =====
// Self-checking testbench for the one-minute OHLC bar builder with a built-in bar predictor.
`timescale 1ns / 1ps

module tick_to_minute_ohlc_bars_tb;
    import ohlc_pkg::*;

    localparam int PICK_FIXED  = 0;
    localparam int PICK_SLOT   = 1;
    localparam int PICK_RANDOM = 2;

    typedef struct packed {
        status_t             st;
        logic [MIN_W-1:0]    minute;
        logic [PRICE_W-1:0]  open_p;
        logic [PRICE_W-1:0]  high_p;
        logic [PRICE_W-1:0]  low_p;
        logic [PRICE_W-1:0]  close_p;
        logic [VOL_W-1:0]    vol;
        logic                day_done;
    } bar_rec_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [1:0]            s_tuser = ACT_TICK;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [2:0]            m_tuser;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = REG_COUNT;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // Predicted configuration and bar state.
    logic [CNT_W-1:0]    sched_count = COUNT_RESET;
    logic [IV_W-1:0]     sched_iv [MAX_INTERVALS] = '{IV0_RESET, IV1_RESET, IV2_RESET, IV3_RESET};
    logic [PTR_W-1:0]    iv_ptr = '0;
    logic [MIN_W-1:0]    slot_q = SLOT_RESET;
    logic [PRICE_W-1:0]  bar_o = '0, bar_h = '0, bar_l = '0, bar_c = '0;
    logic [VOL_W-1:0]    bar_vol = '0;
    logic                bar_traded = 1'b0;
    logic [PRICE_W-1:0]  last_close = '0;
    logic                price_known = 1'b0;
    logic                day_over = 1'b0;

    bar_rec_t bars_pending [$];
    int       mismatches = 0;
    bit       idle_en = 1'b1;

    tick_to_minute_ohlc_bars uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tuser      (m_tuser),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [MIN_W-1:0] iv_first(input logic [PTR_W-1:0] i);
        return (sched_iv[i][10:0] > LAST_MINUTE) ? LAST_MINUTE : sched_iv[i][10:0];
    endfunction

    function automatic logic [MIN_W-1:0] iv_last(input logic [PTR_W-1:0] i);
        return (sched_iv[i][21:11] > LAST_MINUTE) ? LAST_MINUTE : sched_iv[i][21:11];
    endfunction

    function automatic logic [IV_W-1:0] span(input logic [MIN_W-1:0] first,
                                             input logic [MIN_W-1:0] last);
        return {last, first};
    endfunction

    task automatic push_bar(input status_t st, input logic [PRICE_W-1:0] o,
                            input logic [PRICE_W-1:0] h, input logic [PRICE_W-1:0] l,
                            input logic [PRICE_W-1:0] c, input logic [VOL_W-1:0] v,
                            input logic dc);
        bar_rec_t r;
        r = '0;
        r.st = st;
        r.minute = slot_q;
        r.open_p = o;
        r.high_p = h;
        r.low_p = l;
        r.close_p = c;
        r.vol = v;
        r.day_done = dc;
        bars_pending = {bars_pending, r};
    endtask

    task automatic clear_open_bar();
        bar_o = '0;
        bar_h = '0;
        bar_l = '0;
        bar_c = '0;
        bar_vol = '0;
        bar_traded = 1'b0;
    endtask

    // Advances the predicted state by one accepted transaction.
    task automatic fold_transaction(input logic [1:0] act, input logic [MIN_W-1:0] tmin,
                                    input logic [PRICE_W-1:0] price,
                                    input logic [TVOL_W-1:0] tvol);
        int        used;
        logic      at_end;
        logic      last_iv;
        logic [VOL_W:0] sum;
        if (act == ACT_RESTART) begin
            iv_ptr = '0;
            slot_q = iv_first('0);
            clear_open_bar();
            price_known = 1'b0;
            day_over = 1'b0;
        end else if (act == ACT_NONE) begin
            // Ignored by the block.
        end else if (day_over) begin
            push_bar(ST_DONE, '0, '0, '0, '0, '0, 1'b0);
        end else if (act == ACT_TICK) begin
            if (tmin != slot_q) begin
                push_bar(ST_REJECTED, '0, '0, '0, '0, '0, 1'b0);
            end else if (!bar_traded) begin
                bar_o = price;
                bar_h = price;
                bar_l = price;
                bar_c = price;
                bar_vol = VOL_W'(tvol);
                bar_traded = 1'b1;
                price_known = 1'b1;
            end else begin
                if (price > bar_h) bar_h = price;
                if (price < bar_l) bar_l = price;
                bar_c = price;
                sum = {1'b0, bar_vol} + (VOL_W+1)'(tvol);
                bar_vol = sum[VOL_W] ? VOL_MAX : sum[VOL_W-1:0];
                price_known = 1'b1;
            end
        end else begin
            used = (sched_count == 0) ? 1 :
                   (sched_count > MAX_INTERVALS) ? MAX_INTERVALS : int'(sched_count);
            at_end = (slot_q >= iv_last(iv_ptr));
            last_iv = (int'(iv_ptr) + 1 >= used);
            if (bar_traded) begin
                push_bar(ST_TRADED, bar_o, bar_h, bar_l, bar_c, bar_vol, at_end && last_iv);
                last_close = bar_c;
            end else if (price_known) begin
                push_bar(ST_FILLED, last_close, last_close, last_close, last_close, '0,
                         at_end && last_iv);
            end else begin
                push_bar(ST_NO_PRICE, '0, '0, '0, '0, '0, at_end && last_iv);
            end
            if (at_end) begin
                if (last_iv) begin
                    day_over = 1'b1;
                end else begin
                    iv_ptr = iv_ptr + 1'b1;
                    slot_q = iv_first(iv_ptr);
                end
            end else begin
                slot_q = slot_q + 1'b1;
            end
            clear_open_bar();
        end
    endtask

    task automatic check_field(input string name, input logic [VOL_W-1:0] want,
                               input logic [VOL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_bar(input bar_rec_t want);
        check_field("status", VOL_W'(want.st), VOL_W'(m_tuser));
        check_field("bar_minute", VOL_W'(want.minute), VOL_W'(m_tdata[10:0]));
        check_field("open_price", VOL_W'(want.open_p), VOL_W'(m_tdata[42:11]));
        check_field("high_price", VOL_W'(want.high_p), VOL_W'(m_tdata[74:43]));
        check_field("low_price", VOL_W'(want.low_p), VOL_W'(m_tdata[106:75]));
        check_field("close_price", VOL_W'(want.close_p), VOL_W'(m_tdata[138:107]));
        check_field("bar_volume", want.vol, m_tdata[186:139]);
        check_field("day_complete", VOL_W'(want.day_done), VOL_W'(m_tlast));
    endtask

    // Results are checked before the transaction of the same edge is folded in.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (bars_pending.size() == 0) begin
                    $display("%0t: result expected none, actual status %0d minute %0d",
                             $time, m_tuser, m_tdata[10:0]);
                    mismatches++;
                end else begin
                    compare_bar(bars_pending.pop_front());
                end
            end
            if (cfg_wr_en) begin
                if (cfg_wr_index == REG_COUNT)
                    sched_count = cfg_wr_data[CNT_W-1:0];
                else if (cfg_wr_index <= REG_IV3)
                    sched_iv[PTR_W'(cfg_wr_index - REG_IV0)] = cfg_wr_data;
            end
            if (s_tvalid && s_tready)
                fold_transaction(s_tuser, s_tdata[10:0], s_tdata[42:11], s_tdata[74:43]);
        end
    end

    // Result-side back-pressure in random bursts.
    initial begin
        forever begin
            @(negedge aclk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Sends one transaction. The field choice for slot-bound or random items is made
    // at the falling edge, after the previous transaction has been folded in.
    task automatic send_item(input int pick, input logic [1:0] act,
                             input logic [MIN_W-1:0] tmin, input logic [PRICE_W-1:0] price,
                             input logic [TVOL_W-1:0] tvol);
        int roll;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge aclk);
        end
        @(negedge aclk);
        if (pick == PICK_SLOT) begin
            tmin = slot_q;
        end else if (pick == PICK_RANDOM) begin
            roll = $urandom_range(0, 99);
            price = $urandom;
            tvol = ($urandom_range(0, 3) == 0) ? TVOL_W'($urandom_range(0, 999)) : $urandom;
            tmin = slot_q;
            if (day_over && $urandom_range(0, 3) != 0) act = ACT_RESTART;
            else if (roll < 60) act = ACT_TICK;
            else if (roll < 85) act = ACT_CLOSE;
            else if (roll < 91) begin
                act = ACT_TICK;
                tmin = MIN_W'($urandom_range(0, 2047));
            end else if (roll < 95) act = ACT_RESTART;
            else if (roll < 98) begin
                act = ACT_NONE;
                tmin = MIN_W'($urandom_range(0, 2047));
            end else begin
                act = ACT_TICK;
                price = $urandom_range(0, 1) ? '1 : '0;
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {5'd0, tvol, price, tmin};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (bars_pending.size() != 0) @(posedge aclk);
        // Accepted ticks and restarts give no result, so allow the pipeline to empty.
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_reset_schedule();
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        send_item(PICK_FIXED, ACT_TICK, 11'd570, 32'd77, 32'd5);
        send_item(PICK_FIXED, ACT_TICK, 11'h7FF, '1, '1);
        send_item(PICK_SLOT, ACT_TICK, '0, '1, '1);
        send_item(PICK_SLOT, ACT_TICK, '0, '0, '1);
        send_item(PICK_SLOT, ACT_TICK, '0, 32'd1234, '0);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        send_item(PICK_FIXED, ACT_NONE, 11'h7FF, '1, '1);
        send_item(PICK_FIXED, ACT_RESTART, '0, '0, '0);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
    endtask

    task automatic test_schedule_edges();
        // Single interval of two slots, then items after the schedule has finished.
        wait_quiet();
        write_cfg(REG_COUNT, 22'd1);
        write_cfg(REG_IV0, span(11'd5, 11'd6));
        send_item(PICK_FIXED, ACT_RESTART, '0, '0, '0);
        send_item(PICK_SLOT, ACT_TICK, '0, 32'd900, 32'd3);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        send_item(PICK_SLOT, ACT_TICK, '0, 32'd1, 32'd1);
        // An end before the start leaves the start slot alone; a zero count means one.
        wait_quiet();
        write_cfg(REG_COUNT, 22'd0);
        write_cfg(REG_IV0, span(11'd10, 11'd3));
        send_item(PICK_FIXED, ACT_RESTART, '0, '0, '0);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        // Minutes beyond the day are clipped to its last minute.
        wait_quiet();
        write_cfg(REG_IV0, '1);
        send_item(PICK_FIXED, ACT_RESTART, '0, '0, '0);
        send_item(PICK_SLOT, ACT_TICK, '0, 32'd42, 32'd8);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
    endtask

    task automatic test_count_shrink();
        wait_quiet();
        write_cfg(REG_COUNT, 22'd7);
        write_cfg(REG_IV0, span(11'd0, 11'd1));
        write_cfg(REG_IV1, span(11'd2, 11'd3));
        write_cfg(REG_IV2, span(11'd4, 11'd5));
        write_cfg(REG_IV3, span(11'd6, 11'd7));
        send_item(PICK_FIXED, ACT_RESTART, '0, '0, '0);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        // The pointer now sits past the new count; its interval still runs out.
        wait_quiet();
        write_cfg(REG_COUNT, 22'd1);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
    endtask

    // Full-scale tick volumes carry the sum well past 32 bits.
    task automatic test_volume_sum();
        int n;
        wait_quiet();
        idle_en = 1'b0;
        write_cfg(REG_COUNT, 22'd4);
        send_item(PICK_FIXED, ACT_RESTART, '0, '0, '0);
        for (n = 0; n < 40; n++)
            send_item(PICK_SLOT, ACT_TICK, '0, $urandom, '1);
        send_item(PICK_FIXED, ACT_CLOSE, '0, '0, '0);
        idle_en = 1'b1;
    endtask

    task automatic test_random_traffic(input int n_items, input bit with_idle);
        int            n;
        int            k;
        logic [MIN_W-1:0] first;
        logic [MIN_W-1:0] last;
        wait_quiet();
        idle_en = with_idle;
        write_cfg(REG_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
        for (k = 0; k < MAX_INTERVALS; k++) begin
            first = MIN_W'($urandom_range(0, 1439));
            last = first + MIN_W'($urandom_range(0, 10));
            case ($urandom_range(0, 9))
                0: last = MIN_W'($urandom_range(0, 2047));
                1: begin
                    first = MIN_W'($urandom_range(1440, 2047));
                    last = MIN_W'($urandom_range(0, 2047));
                end
                default: ;
            endcase
            write_cfg(CFG_IDX_W'(REG_IV0 + k), span(first, last));
        end
        send_item(PICK_FIXED, ACT_RESTART, '0, '0, '0);
        for (n = 0; n < n_items; n++)
            send_item(PICK_RANDOM, ACT_TICK, '0, '0, '0);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_schedule();
        test_schedule_edges();
        test_count_shrink();
        test_volume_sum();
        repeat (5) test_random_traffic(250, 1'b1);
        test_random_traffic(250, 1'b0);
        wait_quiet();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
